// File: rtl/nearest_neighbor_upscaler_top_macros.svh
// assertion helpers for the upscaler, clocked on aclk and quiet during reset
`ifndef NEAREST_NEIGHBOR_UPSCALER_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_UPSCALER_TOP_MACROS_SVH

// same-cycle implication
`define NNU_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define NNU_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/nnu_pkg.sv
`default_nettype none

package nnu_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_SCALE_DEF = 64;

    localparam int PIXEL_W   = 24;
    localparam int SCALE_W   = 7;
    localparam int WIDTH_W   = 11;
    localparam int ROWS_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

endpackage

`default_nettype wire

// File: rtl/nnu_ram.sv
`default_nettype none

module nnu_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/nearest_neighbor_upscaler_top.sv
`default_nettype none

// Nearest-neighbour upscaler for 24-bit pixels. A source pixel item is stored in the line
// memory and leaves as scale_factor copies; once line_width pixels have arrived, scale_factor-1
// replays of the row are pending and each tick item reads one stored pixel back and sends it out
// scale_factor times. A pixel arriving while replays are pending is dropped and gives a single
// result with overrun set; a tick with nothing pending gives no result. Results leave one per
// cycle from the output register while m_ready is high, and an item holds the output until
// its last result is taken. The first result of an item, replays included, reaches the output
// register by way of the middle stage, as the line memory read completes while the item waits
// in the middle stage.
// Input and output are parted by a one-item stage, so the next item is taken while copies of
// the previous one are still draining. The line memory needs no clearing after reset.
// Configuration is written through cfg_* and is always ready.

`include "nearest_neighbor_upscaler_top_macros.svh"

module nearest_neighbor_upscaler_top #(
    parameter int MAX_WIDTH = nnu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = nnu_pkg::MAX_SCALE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nnu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nnu_pkg::CFG_DAT_W-1:0] cfg_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [7:0]                    s_blue,
    input  wire logic [7:0]                    s_green,
    input  wire logic [7:0]                    s_red,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [7:0]                    m_out_blue,
    output logic      [7:0]                    m_out_green,
    output logic      [7:0]                    m_out_red,
    output logic                               m_last_copy,
    output logic                               m_end_of_row,
    output logic      [1:0]                    m_pad_bytes,
    output logic                               m_overrun
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W  = (ADDR_W + 1 > nnu_pkg::WIDTH_W + 1) ? ADDR_W + 1
                                                               : nnu_pkg::WIDTH_W + 1;
    localparam int SW     = nnu_pkg::SCALE_W;
    localparam int PW     = nnu_pkg::PIXEL_W;
    localparam int RW     = nnu_pkg::ROWS_W;

    // configuration
    logic [SW-1:0]                  scale_reg;
    logic [nnu_pkg::WIDTH_W-1:0]    width_reg;
    logic [SW-1:0]                  s_eff;
    logic [CMP_W-1:0]               w_eff;
    logic [CMP_W-1:0]               width_ext;
    logic [1:0]                     pad_mod;
    logic [1:0]                     pad;

    // row bookkeeping
    logic [ADDR_W-1:0]              capture_col_reg;
    logic [ADDR_W-1:0]              replay_col_reg;
    logic [RW-1:0]                  rows_left_reg;
    logic                           cap_row_end;
    logic                           rep_row_end;

    logic                           s_accept;
    logic                           is_tick;
    logic                           replay_pending;
    logic                           capture;
    logic                           overrun_hit;
    logic                           replay;

    // one-item stage between input and output
    logic                           a_valid_reg;
    logic [PW-1:0]                  a_pix_reg;
    logic                           a_from_ram_reg;
    logic                           a_overrun_reg;
    logic                           a_row_end_reg;
    logic                           e_take;

    // line memory
    logic [PW-1:0]                  ram_rdata;

    // output register and copy counter
    logic                           m_valid_reg;
    logic [SW-1:0]                  copy_left_reg;
    logic                           row_end_keep_reg;
    logic [7:0]                     blue_reg;
    logic [7:0]                     green_reg;
    logic [7:0]                     red_reg;
    logic                           last_copy_reg;
    logic                           end_of_row_reg;
    logic [1:0]                     pad_bytes_reg;
    logic                           overrun_reg;

    logic [PW-1:0]                  ld_pix;
    logic [SW-1:0]                  ld_left;
    logic                           ld_last;
    logic                           ld_row_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SW'(1);
            width_reg <= nnu_pkg::WIDTH_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nnu_pkg::REG_SCALE: begin
                    scale_reg <= cfg_data[SW-1:0];
                end
                nnu_pkg::REG_WIDTH: begin
                    width_reg <= cfg_data[nnu_pkg::WIDTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamped factor and width, row padding
    assign width_ext = CMP_W'(width_reg);

    always_comb begin
        if (scale_reg == '0) begin
            s_eff = SW'(1);
        end else if (scale_reg > SW'(MAX_SCALE)) begin
            s_eff = SW'(MAX_SCALE);
        end else begin
            s_eff = scale_reg;
        end
        if (width_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = width_ext;
        end
    end

    assign pad_mod = 2'(w_eff[1:0] * s_eff[1:0] * 2'd3);
    assign pad     = 2'(2'd0 - pad_mod);

    // input decode
    assign s_accept       = s_valid && s_ready;
    assign is_tick        = (s_kind == nnu_pkg::KIND_TICK);
    assign replay_pending = (rows_left_reg != '0);
    assign capture        = s_accept && !is_tick && !replay_pending;
    assign overrun_hit    = s_accept && !is_tick && replay_pending;
    assign replay         = s_accept && is_tick && replay_pending;

    assign cap_row_end = (CMP_W'(capture_col_reg) + CMP_W'(1) >= w_eff);
    assign rep_row_end = (CMP_W'(replay_col_reg) + CMP_W'(1) >= w_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_col_reg <= '0;
            replay_col_reg  <= '0;
            rows_left_reg   <= '0;
        end else if (capture) begin
            if (cap_row_end) begin
                capture_col_reg <= '0;
                replay_col_reg  <= '0;
                rows_left_reg   <= RW'(s_eff - SW'(1));
            end else begin
                capture_col_reg <= capture_col_reg + ADDR_W'(1);
            end
        end else if (replay) begin
            if (rep_row_end) begin
                replay_col_reg <= '0;
                rows_left_reg  <= rows_left_reg - RW'(1);
            end else begin
                replay_col_reg <= replay_col_reg + ADDR_W'(1);
            end
        end
    end

    // writes and reads never share a cycle: at most one item is accepted per cycle, and it is one or the other
    nnu_ram #(
        .WIDTH  (PW),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk  (aclk),
        .we    (capture),
        .waddr (capture_col_reg),
        .wdata ({s_red, s_green, s_blue}),
        .re    (replay),
        .raddr (replay_col_reg),
        .rdata (ram_rdata)
    );

    // middle stage
    assign e_take  = a_valid_reg && (!m_valid_reg || (m_ready && copy_left_reg == '0));
    assign s_ready = !a_valid_reg || e_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (capture || overrun_hit || replay) begin
            a_valid_reg <= 1'b1;
        end else if (e_take) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_pix_reg      <= {s_red, s_green, s_blue};
            a_from_ram_reg <= is_tick;
            a_overrun_reg  <= overrun_hit;
            a_row_end_reg  <= is_tick ? rep_row_end : cap_row_end;
        end
    end

    // output loading
    always_comb begin
        if (a_overrun_reg) begin
            ld_pix = '0;
        end else if (a_from_ram_reg) begin
            ld_pix = ram_rdata;
        end else begin
            ld_pix = a_pix_reg;
        end
    end

    assign ld_left    = a_overrun_reg ? '0 : (s_eff - SW'(1));
    assign ld_last    = (ld_left == '0) && !a_overrun_reg;
    assign ld_row_end = a_row_end_reg && !a_overrun_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            copy_left_reg <= '0;
        end else if (e_take) begin
            m_valid_reg   <= 1'b1;
            copy_left_reg <= ld_left;
        end else if (m_valid_reg && m_ready) begin
            if (copy_left_reg != '0) begin
                copy_left_reg <= copy_left_reg - SW'(1);
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_take) begin
            blue_reg         <= ld_pix[7:0];
            green_reg        <= ld_pix[15:8];
            red_reg          <= ld_pix[23:16];
            overrun_reg      <= a_overrun_reg;
            row_end_keep_reg <= ld_row_end;
            last_copy_reg    <= ld_last;
            end_of_row_reg   <= ld_last && ld_row_end;
            pad_bytes_reg    <= (ld_last && ld_row_end) ? pad : 2'd0;
        end else if (m_valid_reg && m_ready && copy_left_reg != '0) begin
            last_copy_reg    <= (copy_left_reg == SW'(1));
            end_of_row_reg   <= (copy_left_reg == SW'(1)) && row_end_keep_reg;
            pad_bytes_reg    <= ((copy_left_reg == SW'(1)) && row_end_keep_reg) ? pad : 2'd0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_blue   = blue_reg;
    assign m_out_green  = green_reg;
    assign m_out_red    = red_reg;
    assign m_last_copy  = last_copy_reg;
    assign m_end_of_row = end_of_row_reg;
    assign m_pad_bytes  = pad_bytes_reg;
    assign m_overrun    = overrun_reg;

    `NNU_ASSERT_NOW(a_overrun_single, m_valid_reg && overrun_reg, copy_left_reg == '0 && !last_copy_reg, "overrun item must give one result")
    `NNU_ASSERT_NOW(a_ram_one_port, 1'b1, !(capture && replay), "line memory written and read together")
    `NNU_ASSERT_NEXT(a_copy_holds, m_valid_reg && m_ready && copy_left_reg != '0, m_valid_reg && $stable(blue_reg) && $stable(red_reg), "copies of one pixel broke up")
    `NNU_ASSERT_NOW(a_row_end_last, m_valid_reg && end_of_row_reg, last_copy_reg, "row end off the last copy")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nnu_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 176;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last_copy;
        logic       end_of_row;
        logic [1:0] pad_bytes;
        logic       overrun;
    } out_pixel_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic [7:0]           s_blue;
    logic [7:0]           s_green;
    logic [7:0]           s_red;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_out_blue;
    logic [7:0]           m_out_green;
    logic [7:0]           m_out_red;
    logic                 m_last_copy;
    logic                 m_end_of_row;
    logic [1:0]           m_pad_bytes;
    logic                 m_overrun;

    // upscaler prediction state
    logic [23:0]  row_mem [MAX_WIDTH_DEF];
    bit           row_mem_written [MAX_WIDTH_DEF];
    int unsigned  cap_col = 0;
    int unsigned  rep_col = 0;
    logic [5:0]   rows_left = '0;
    logic [6:0]   scale_reg = 7'd1;
    logic [10:0]  width_reg = 11'd1;
    out_pixel_t   expected_px [$];

    int unsigned errors = 0;
    int unsigned px_checked = 0;
    int unsigned items_taken = 0;
    int unsigned overruns = 0;
    int unsigned ignored_ticks = 0;
    int unsigned rows_out = 0;
    int unsigned max_scale_seen = 1;
    int unsigned max_width_seen = 1;
    int unsigned cycles = 0;

    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    bit          rx_hold_req = 1'b0;
    bit          rx_took = 1'b0;
    int unsigned rx_wait = 0;

    nearest_neighbor_upscaler_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_blue       (s_blue),
        .s_green      (s_green),
        .s_red        (s_red),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_blue   (m_out_blue),
        .m_out_green  (m_out_green),
        .m_out_red    (m_out_red),
        .m_last_copy  (m_last_copy),
        .m_end_of_row (m_end_of_row),
        .m_pad_bytes  (m_pad_bytes),
        .m_overrun    (m_overrun)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_scale(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > MAX_SCALE_DEF) return MAX_SCALE_DEF;
        return v;
    endfunction

    function automatic int unsigned clamp_width(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return v;
    endfunction

    // a wider row may only be replayed from columns that hold real pixels
    function automatic bit width_write_ok(input logic [10:0] data);
        int unsigned w;
        w = clamp_width(data);
        if (rows_left == 0) return 1'b1;
        for (int unsigned c = 0; c < w; c++) begin
            if (!row_mem_written[c]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_upscale(input logic kind, input logic [23:0] px_in,
                                   output int unsigned n_out);
        int unsigned s;
        int unsigned w;
        int unsigned pad;
        int unsigned copies;
        logic [23:0] px;
        logic        row_end;
        out_pixel_t  o;
        s = clamp_scale(scale_reg);
        w = clamp_width(width_reg);
        pad = (4 - ((w * s * 3) % 4)) % 4;
        copies = 0;
        row_end = 1'b0;
        px = '0;
        n_out = 0;
        if (kind == KIND_PIXEL && rows_left != 0) begin
            o = '0;
            o.overrun = 1'b1;
            expected_px.push_back(o);
            overruns++;
            n_out = 1;
        end else if (kind == KIND_PIXEL) begin
            px = px_in;
            row_mem[cap_col] = px;
            row_mem_written[cap_col] = 1'b1;
            row_end = (cap_col + 1 >= w);
            if (row_end) begin
                cap_col = 0;
                rep_col = 0;
                rows_left = 6'(s - 1);
            end else begin
                cap_col++;
            end
            copies = s;
        end else if (rows_left != 0) begin
            px = row_mem[rep_col];
            row_end = (rep_col + 1 >= w);
            if (row_end) begin
                rep_col = 0;
                rows_left = rows_left - 6'd1;
            end else begin
                rep_col++;
            end
            copies = s;
        end else begin
            ignored_ticks++;
        end
        for (int unsigned k = 0; k < copies; k++) begin
            o.blue       = px[7:0];
            o.green      = px[15:8];
            o.red        = px[23:16];
            o.last_copy  = (k + 1 == copies);
            o.end_of_row = o.last_copy && row_end;
            o.pad_bytes  = o.end_of_row ? 2'(pad) : 2'd0;
            o.overrun    = 1'b0;
            expected_px.push_back(o);
        end
        if (row_end) rows_out++;
        if (copies != 0) n_out = copies;
        if (n_out != 0) items_taken++;
    endtask

    task automatic send_item(input logic kind, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r, output int unsigned n_out);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_blue  <= b;
        s_green <= g;
        s_red   <= r;
        do @(posedge aclk); while (!s_ready);
        predict_upscale(kind, {r, g, b}, n_out);
    endtask

    task automatic send_random_item(output int unsigned n_out);
        logic kind;
        if (rows_left != 0) begin
            kind = ($urandom_range(0, 7) == 0) ? KIND_PIXEL : KIND_TICK;
        end else begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_TICK : KIND_PIXEL;
        end
        send_item(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), n_out);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SCALE) begin
            scale_reg = data[6:0];
            if (clamp_scale(scale_reg) > max_scale_seen) max_scale_seen = clamp_scale(scale_reg);
        end else begin
            width_reg = data;
            if (clamp_width(width_reg) > max_width_seen) max_width_seen = clamp_width(width_reg);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering items and let every pending output pixel drain
    task automatic go_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        int unsigned n;
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00, n);
        send_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, n);
        send_item(KIND_TICK, 8'hA5, 8'h5A, 8'hC3, n);
    endtask

    task automatic test_zero_registers();
        int unsigned n;
        go_idle();
        write_reg(REG_SCALE, 11'h080);
        write_reg(REG_WIDTH, 11'h000);
        send_item(KIND_PIXEL, 8'h12, 8'h34, 8'h56, n);
    endtask

    task automatic test_row_replay();
        int unsigned n;
        go_idle();
        write_reg(REG_SCALE, 11'd3);
        write_reg(REG_WIDTH, 11'd2);
        send_item(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, n);
        send_item(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, n);
        send_item(KIND_PIXEL, 8'h77, 8'h88, 8'h99, n);
        send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
        send_item(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, n);
        // new scale while a replay is still owed
        go_idle();
        write_reg(REG_SCALE, 11'd5);
        send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
        send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
        send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
    endtask

    task automatic test_width_cut();
        int unsigned n;
        go_idle();
        write_reg(REG_SCALE, 11'd127);
        write_reg(REG_WIDTH, 11'd2047);
        send_item(KIND_PIXEL, 8'h01, 8'h02, 8'h03, n);
        send_item(KIND_PIXEL, 8'h80, 8'h40, 8'h20, n);
        go_idle();
        write_reg(REG_WIDTH, 11'd1024);
        send_item(KIND_PIXEL, 8'hFE, 8'h7F, 8'h01, n);
        // row already past the new width, so the next pixel closes it
        go_idle();
        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_SCALE, 11'd2);
        send_item(KIND_PIXEL, 8'h3C, 8'hC3, 8'h66, n);
        send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
        send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
    endtask

    task automatic test_max_scale();
        int unsigned n;
        go_idle();
        write_reg(REG_SCALE, 11'd64);
        write_reg(REG_WIDTH, 11'd1);
        send_item(KIND_PIXEL, 8'hAA, 8'h55, 8'hF0, n);
        repeat (3) send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, n);
    endtask

    task automatic test_backpressure();
        int unsigned n;
        go_idle();
        write_reg(REG_SCALE, 11'd4);
        if (width_write_ok(11'd3)) write_reg(REG_WIDTH, 11'd3);
        tx_quiet = 1'b1;
        rx_hold_req = 1'b1;
        repeat (12) send_random_item(n);
        go_idle();
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_images();
        int unsigned n;
        int unsigned phase_len;
        int unsigned counted;
        logic [10:0] new_scale;
        logic [10:0] new_width;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            go_idle();
            case ($urandom_range(0, 11))
                0:          new_scale = 11'h000;
                1:          new_scale = 11'h080;
                2, 3, 4, 5: new_scale = 11'($urandom_range(1, 4));
                6, 7:       new_scale = 11'($urandom_range(5, 9));
                8:          new_scale = 11'($urandom_range(0, 2047));
                9:          new_scale = 11'($urandom_range(64, 127));
                default:    new_scale = 11'd2;
            endcase
            case ($urandom_range(0, 9))
                0:             new_width = 11'd0;
                1, 2, 3, 4, 5: new_width = 11'($urandom_range(1, 6));
                6, 7:          new_width = 11'($urandom_range(7, 16));
                8:             new_width = 11'($urandom_range(1024, 2047));
                default:       new_width = 11'($urandom_range(0, 2047));
            endcase
            write_reg(REG_SCALE, new_scale);
            if (width_write_ok(new_width)) write_reg(REG_WIDTH, new_width);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 30);
            repeat (phase_len) begin
                if (counted < RANDOM_ITEMS) begin
                    send_random_item(n);
                    counted++;
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // receiver: per output pixel wait, plus one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_hold_req) begin
                rx_wait = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else if (rx_took) begin
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            rx_took = 1'b0;
            if (rx_wait != 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : out_check
        out_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_took = 1'b1;
            if (expected_px.size() == 0) begin
                $display("%0t: output pixel with nothing expected, actual %h %h %h", $time,
                         m_out_blue, m_out_green, m_out_red);
                errors++;
            end else begin
                want = expected_px.pop_front();
                check_field("out_blue", want.blue, m_out_blue);
                check_field("out_green", want.green, m_out_green);
                check_field("out_red", want.red, m_out_red);
                check_field("last_copy", want.last_copy, m_last_copy);
                check_field("end_of_row", want.end_of_row, m_end_of_row);
                check_field("pad_bytes", want.pad_bytes, m_pad_bytes);
                check_field("overrun", want.overrun, m_overrun);
                px_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d output pixels outstanding", $time,
                     expected_px.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_kind    = KIND_PIXEL;
        s_blue    = '0;
        s_green   = '0;
        s_red     = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_zero_registers();
        test_row_replay();
        test_width_cut();
        test_max_scale();
        test_backpressure();
        test_random_images();

        go_idle();
        repeat (20) @(posedge aclk);

        $display("%0d items took effect (%0d overruns), %0d ignored ticks, %0d output rows",
                 items_taken, overruns, ignored_ticks, rows_out);
        $display("%0d output pixels checked, scale up to %0d, width up to %0d, %0d errors",
                 px_checked, max_scale_seen, max_width_seen, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
